// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define GNC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Check that a condition never holds outside reset.
`define GNC_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `GNC_ASSERT(lbl, clk, rstn, !(cond), msg)

`endif

// ===== rtl/gnc_pkg.sv =====
`default_nettype none

package gnc_pkg;

  localparam int unsigned MAX_SIZE = 32;
  localparam int unsigned COL_W    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int unsigned SIZE_W   = 6;
  localparam int unsigned COUNT_W  = 4;
  localparam int unsigned COORD_W  = 5;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd8;

  // line store entry: row tag of the write, then the older and the newer row
  localparam int unsigned LINE_W = COL_W + 2;

  typedef struct packed {
    logic [COL_W-1:0] row;    // row of the cell written with this entry
    logic             older;  // bit of the row before it
    logic             newer;  // bit of the row itself
  } line_t;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;
  localparam int unsigned FIFO_CNT_W = 3;

  typedef struct packed {
    logic [COUNT_W-1:0] window_count;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } result_t;

  // one column of the window moving through the count stage
  typedef struct packed {
    logic             flush;    // column replayed for the last row
    logic             emit_en;  // counts for the center row are due
    logic             at_end;   // column is the last one of the row
    logic [COL_W-1:0] row;      // row of the centers this column closes
    logic [COL_W-1:0] col;
  } col_ev_t;

endpackage

`default_nettype wire

// ===== rtl/gnc_ram.sv =====
`default_nettype none

module gnc_ram #(
  parameter int unsigned Width = 2,
  parameter int unsigned Depth = 32
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                              wdata_i,
  input  wire logic                                          re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                              rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/gnc_window.sv =====
`default_nettype none

module gnc_window (
  input  wire logic             clk_i,
  input  wire logic             fire_i,
  input  wire gnc_pkg::col_ev_t ev_i,
  input  wire logic [2:0]       col_bits_i,
  output gnc_pkg::result_t      res_a_o,
  output logic                  res_a_vld_o,
  output gnc_pkg::result_t      res_b_o,
  output logic                  res_b_vld_o
);

  function automatic logic [gnc_pkg::COUNT_W-1:0] pop3(input logic [2:0] v);
    return gnc_pkg::COUNT_W'(v[0]) + gnc_pkg::COUNT_W'(v[1]) + gnc_pkg::COUNT_W'(v[2]);
  endfunction

  // two columns to the left of the incoming one
  logic [2:0] w1_q;
  logic [2:0] w2_q;
  logic [2:0] left_a;
  logic [2:0] left_b;

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      w2_q <= w1_q;
      w1_q <= col_bits_i;
    end
  end

  always_comb begin
    left_a = (ev_i.col > gnc_pkg::COL_W'(1)) ? w2_q : 3'b000;
    left_b = (ev_i.col != '0) ? w1_q : 3'b000;

    // center one column back: left, center and incoming column
    res_a_o.window_count = pop3(left_a) + pop3(w1_q) + pop3(col_bits_i);
    res_a_o.row          = gnc_pkg::COORD_W'(ev_i.row);
    res_a_o.col          = gnc_pkg::COORD_W'(ev_i.col - gnc_pkg::COL_W'(1));
    res_a_o.last         = 1'b0;
    res_a_vld_o          = ev_i.emit_en && (ev_i.col != '0);

    // center on the last column: right side lies outside the grid
    res_b_o.window_count = pop3(left_b) + pop3(col_bits_i);
    res_b_o.row          = gnc_pkg::COORD_W'(ev_i.row);
    res_b_o.col          = gnc_pkg::COORD_W'(ev_i.col);
    res_b_o.last         = ev_i.flush;
    res_b_vld_o          = ev_i.emit_en && ev_i.at_end;
  end

endmodule

`default_nettype wire

// ===== rtl/gnc_ofifo.sv =====
`default_nettype none

module gnc_ofifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_a_i,
  input  wire gnc_pkg::result_t data_a_i,
  input  wire logic             push_b_i,
  input  wire gnc_pkg::result_t data_b_i,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output gnc_pkg::result_t      head_o,
  output logic                  room_o
);

  gnc_pkg::result_t                  mem_q [gnc_pkg::FIFO_DEPTH];
  logic [gnc_pkg::FIFO_PTR_W-1:0]    wptr_q, wptr_d, wptr_b;
  logic [gnc_pkg::FIFO_PTR_W-1:0]    rptr_q, rptr_d;
  logic [gnc_pkg::FIFO_CNT_W-1:0]    cnt_q, cnt_d;
  logic [1:0]                        n_push;

  always_comb begin
    n_push = {1'b0, push_a_i} + {1'b0, push_b_i};
    wptr_b = push_a_i ? (wptr_q + gnc_pkg::FIFO_PTR_W'(1)) : wptr_q;
    wptr_d = wptr_q + gnc_pkg::FIFO_PTR_W'(n_push);
    rptr_d = rptr_q + gnc_pkg::FIFO_PTR_W'(pop_i);
    cnt_d  = cnt_q + gnc_pkg::FIFO_CNT_W'(n_push) - gnc_pkg::FIFO_CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_a_i) begin
      mem_q[wptr_q] <= data_a_i;
    end
    if (push_b_i) begin
      mem_q[wptr_b] <= data_b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rptr_q];
  // room for the two results one column can close
  assign room_o  = (cnt_q <= gnc_pkg::FIFO_CNT_W'(gnc_pkg::FIFO_DEPTH - 2));

endmodule

`default_nettype wire

// ===== rtl/grid_neighbour_count_3x3_top.sv =====
// Channel   Direction  Handshake                  Payload
// in        request    in_valid_i / in_ready_o    cell_set_i
// out       result     out_valid_o / out_ready_i  window_count_o, out_row_o, out_col_o,
//                                                 last_of_grid_o
// cfg       write      cfg_we_i                   cfg_wdata_i (grid_size)
//
// One cell is taken per cycle while in_ready_o is high; the line store RAM (one read,
// one write port) is read on accept and written back when the count stage fires, one
// column per cycle unless that stage stalls. A cell on the last column of a row below
// the first closes two results, the final cell of the grid n+2 for n > 1; the last
// row is then replayed from the line store. Results leave one per cycle while
// out_ready_i is high, through a 4-entry queue. Reset needs no clearing pass: a row
// tag in each entry and per-column valid bits, cleared when a grid starts, mask
// stale data. out_ready_i low fills the queue and then holds the count stage and in.
`default_nettype none

`include "assert_macros.svh"

module grid_neighbour_count_3x3_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          cell_set_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [gnc_pkg::COUNT_W-1:0]        window_count_o,
  output logic [gnc_pkg::COORD_W-1:0]        out_row_o,
  output logic [gnc_pkg::COORD_W-1:0]        out_col_o,
  output logic                               last_of_grid_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [gnc_pkg::SIZE_W-1:0]    cfg_wdata_i
);

  typedef enum logic {
    ST_RUN,
    ST_FLUSH
  } state_e;

  localparam int unsigned ColW = gnc_pkg::COL_W;

  state_e state_q;
  logic [ColW-1:0] fl_col_q;

  logic [gnc_pkg::SIZE_W-1:0] grid_size_q;
  logic [gnc_pkg::SIZE_W-1:0] n_eff;
  logic [ColW-1:0]            n_m1;

  // position of the next cell
  logic [ColW-1:0] row_q, col_q;
  logic [ColW-1:0] cur_r, cur_c;
  logic            restart;
  logic            cur_final;

  // count stage
  logic             p_vld_q;
  gnc_pkg::col_ev_t p_ev_q;
  logic             p_cell_q;
  logic [ColW-1:0]  p_row_q;
  logic             p_final_q;
  logic             p_fire, p_free;
  logic             enter_flush;
  logic             fl_load;
  logic             in_accept;

  // line store access
  logic                        rd_en, wr_en;
  logic [ColW-1:0]             rd_addr, wr_addr;
  gnc_pkg::line_t              wr_data, ram_rdata, line_word;
  logic                        fwd_q;
  gnc_pkg::line_t              fwd_word_q;
  logic [2:0]                  col_bits;
  logic                        row_ge1, row_ge2;

  // entries written in the current grid
  logic [gnc_pkg::MAX_SIZE-1:0] col_vld_q, col_vld_d;
  logic                         grid_start;
  logic                         line_vld_q, line_hit;
  logic                         hit_one, hit_two;
  logic                         newer_bit, older_bit;

  gnc_pkg::result_t res_a, res_b, head;
  logic             res_a_vld, res_b_vld;
  logic             fifo_room;

  // clamp the size into 1..MAX_SIZE
  always_comb begin
    if (grid_size_q == '0) begin
      n_eff = gnc_pkg::SIZE_W'(1);
    end else if (grid_size_q > gnc_pkg::SIZE_W'(gnc_pkg::MAX_SIZE)) begin
      n_eff = gnc_pkg::SIZE_W'(gnc_pkg::MAX_SIZE);
    end else begin
      n_eff = grid_size_q;
    end
    n_m1 = ColW'(n_eff - gnc_pkg::SIZE_W'(1));
  end

  // a position outside a shrunk grid starts a new grid
  assign restart   = (row_q > n_m1) || (col_q > n_m1);
  assign cur_r     = restart ? '0 : row_q;
  assign cur_c     = restart ? '0 : col_q;
  assign cur_final = (cur_r == n_m1) && (cur_c == n_m1);

  assign p_fire      = p_vld_q && fifo_room;
  assign p_free      = !p_vld_q || p_fire;
  assign enter_flush = p_fire && p_final_q;
  assign in_ready_o  = (state_q == ST_RUN) && p_free && !enter_flush;
  assign in_accept   = in_valid_i && in_ready_o;
  assign fl_load     = (state_q == ST_FLUSH) && p_free;

  assign rd_en   = in_accept || fl_load;
  assign rd_addr = fl_load ? fl_col_q : cur_c;
  assign wr_en   = p_fire && !p_ev_q.flush;
  assign wr_addr = p_ev_q.col;

  // drop every entry of the old grid when cell (0,0) comes in
  assign grid_start = in_accept && (cur_r == '0) && (cur_c == '0);

  always_comb begin
    col_vld_d = col_vld_q;
    if (wr_en) begin
      col_vld_d[wr_addr] = 1'b1;
    end
    if (grid_start) begin
      col_vld_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_vld_q <= '0;
    end else begin
      col_vld_q <= col_vld_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q <= gnc_pkg::SIZE_RESET;
    end else if (cfg_we_i) begin
      grid_size_q <= cfg_wdata_i;
    end
  end

  // advance the position on every accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (in_accept) begin
      if (cur_c == n_m1) begin
        row_q <= cur_final ? '0 : ColW'(cur_r + ColW'(1));
        col_q <= '0;
      end else begin
        row_q <= cur_r;
        col_q <= ColW'(cur_c + ColW'(1));
      end
    end
  end

  // replay sequencer for the last row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_RUN;
      fl_col_q <= '0;
    end else begin
      case (state_q)
        ST_RUN: begin
          if (enter_flush) begin
            state_q  <= ST_FLUSH;
            fl_col_q <= '0;
          end
        end
        ST_FLUSH: begin
          if (fl_load) begin
            fl_col_q <= ColW'(fl_col_q + ColW'(1));
            if (fl_col_q == n_m1) begin
              state_q <= ST_RUN;
            end
          end
        end
        default: begin
          state_q <= ST_RUN;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else if (rd_en) begin
      p_vld_q <= 1'b1;
    end else if (p_fire) begin
      p_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      p_ev_q.flush   <= 1'b0;
      p_ev_q.emit_en <= (cur_r != '0);
      p_ev_q.at_end  <= (cur_c == n_m1);
      p_ev_q.row     <= ColW'(cur_r - ColW'(1));
      p_ev_q.col     <= cur_c;
      p_cell_q       <= cell_set_i;
      p_row_q        <= cur_r;
      p_final_q      <= cur_final;
    end else if (fl_load) begin
      p_ev_q.flush   <= 1'b1;
      p_ev_q.emit_en <= 1'b1;
      p_ev_q.at_end  <= (fl_col_q == n_m1);
      p_ev_q.row     <= n_m1;
      p_ev_q.col     <= fl_col_q;
      p_cell_q       <= 1'b0;
      p_row_q        <= n_m1;
      p_final_q      <= 1'b0;
    end
  end

  // forward a write-back that hits the entry read in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q      <= 1'b0;
      line_vld_q <= 1'b0;
    end else if (rd_en) begin
      fwd_q      <= wr_en && (wr_addr == rd_addr);
      line_vld_q <= col_vld_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      fwd_word_q <= wr_data;
    end
  end

  assign line_word = fwd_q ? fwd_word_q : ram_rdata;
  assign row_ge1   = (p_row_q != '0);
  assign row_ge2   = (p_row_q > ColW'(1));

  // an entry written one row back holds both rows, one written two rows back
  // holds only the older row; anything else reads as clear
  assign line_hit  = fwd_q || line_vld_q;
  assign hit_one   = line_hit && (line_word.row == p_ev_q.row);
  assign hit_two   = line_hit && (line_word.row == ColW'(p_ev_q.row - ColW'(1)));
  assign newer_bit = hit_one && line_word.newer;
  assign older_bit = (hit_one && line_word.older) || (hit_two && line_word.newer);

  // rows above the grid read as clear; the last row replays with nothing below
  always_comb begin
    if (p_ev_q.flush) begin
      col_bits = {older_bit & row_ge1, newer_bit, 1'b0};
    end else begin
      col_bits = {older_bit & row_ge2, newer_bit & row_ge1, p_cell_q};
    end
    wr_data.row   = p_row_q;
    wr_data.older = col_bits[1];
    wr_data.newer = p_cell_q;
  end

  gnc_ram #(
    .Width(gnc_pkg::LINE_W),
    .Depth(gnc_pkg::MAX_SIZE)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  gnc_window u_window (
    .clk_i      (clk_i),
    .fire_i     (p_fire),
    .ev_i       (p_ev_q),
    .col_bits_i (col_bits),
    .res_a_o    (res_a),
    .res_a_vld_o(res_a_vld),
    .res_b_o    (res_b),
    .res_b_vld_o(res_b_vld)
  );

  gnc_ofifo u_ofifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_a_i(p_fire && res_a_vld),
    .data_a_i(res_a),
    .push_b_i(p_fire && res_b_vld),
    .data_b_i(res_b),
    .pop_i   (out_valid_o && out_ready_i),
    .valid_o (out_valid_o),
    .head_o  (head),
    .room_o  (fifo_room)
  );

  assign window_count_o = head.window_count;
  assign out_row_o      = head.row;
  assign out_col_o      = head.col;
  assign last_of_grid_o = head.last;

  `GNC_ASSERT_NEVER(a_no_request_in_flush, clk_i, rst_ni, (state_q == ST_FLUSH) && in_accept, "request taken during last-row replay")
  `GNC_ASSERT(a_request_enters_stage, clk_i, rst_ni, in_accept |=> (p_vld_q && !p_ev_q.flush), "accepted request missing from count stage")
  `GNC_ASSERT(a_last_on_final_col, clk_i, rst_ni, (out_valid_o && last_of_grid_o) |-> (out_col_o == gnc_pkg::COORD_W'(n_m1)), "grid end flagged off the last column")

endmodule

`default_nettype wire
